// File: rtl/core/pit_pkg.sv
// Shared types and constants for the point-in-tetrahedron test core.
package pit_pkg;
	typedef enum logic [1:0] {
		OP_WR_VERTEX = 2'd0,
		OP_WR_CELL   = 2'd1,
		OP_QUERY     = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DEGEN  = 2'd1,
		ST_RANGE  = 2'd2,
		ST_RSVD   = 2'd3
	} status_t;

	localparam int unsigned IDX_W   = 12;
	localparam int unsigned CCNT_W  = 13;
	localparam int unsigned TOL_W   = 30;
	localparam int unsigned WGT_W   = 32;
	localparam int unsigned FRAC_Q  = 30;
	// quotient capped at 2^33, so 34 bits
	localparam int unsigned QUO_W   = 34;

	localparam logic [0:0] REG_CELL_COUNT = 1'b0;
	localparam logic [0:0] REG_TOLERANCE  = 1'b1;
endpackage

// File: rtl/core/point_in_tetrahedron_test_core.sv
// Top level of the point-in-tetrahedron test core: tables, determinants, division.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+------------------------
//  item in  | op index coord_x/y/z corner0..3              | start & !busy
//  result   | inside_res status weight0..3                 | done strobe, one cycle
//  config   | psel penable pwrite paddr pwdata prdata      | APB, pready tied high
//
// One item enters every cycle; busy is always low. A query result passes the
// table, determinant and magnitude registers and then the divider, where NSTEP
// (108 with the default parameters) is the number of quotient bits of the
// restoring divider pipeline (one quotient bit per stage, four lanes).
// Writes give no result. arst_n clears valid bits and registers only; the
// tables are undefined until written. The receiver cannot stall, so nothing holds.
module point_in_tetrahedron_test_core #(
	parameter int unsigned MAX_VERTICES = 4096,
	parameter int unsigned MAX_CELLS    = 4096,
	parameter int unsigned COORD_WIDTH  = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              op,
	input  logic [11:0]             index,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic signed [COORD_WIDTH-1:0] coord_z,
	input  logic [11:0]             corner0,
	input  logic [11:0]             corner1,
	input  logic [11:0]             corner2,
	input  logic [11:0]             corner3,
	output logic                    done,
	output logic                    inside_res,
	output logic [1:0]              status,
	output logic signed [31:0]      weight0,
	output logic signed [31:0]      weight1,
	output logic signed [31:0]      weight2,
	output logic signed [31:0]      weight3,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	localparam int unsigned VA_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int unsigned CA_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int unsigned CW   = COORD_WIDTH;
	localparam int unsigned DW   = CW + 1;             // difference width
	localparam int unsigned P2W  = 2 * DW;             // 2-term product
	localparam int unsigned M2W  = P2W + 1;            // 2x2 minor
	localparam int unsigned ML_W = (M2W + 1) / 2;      // low half of a minor
	localparam int unsigned MH_W = M2W - ML_W;         // high half of a minor
	localparam int unsigned PLW  = DW + ML_W + 1;      // diff times low half
	localparam int unsigned PHW  = DW + MH_W;          // diff times high half
	localparam int unsigned SLW  = PLW + 2;            // sum of three low parts
	localparam int unsigned SHW  = PHW + 2;            // sum of three high parts
	localparam int unsigned P3W  = M2W + DW;           // minor times diff
	localparam int unsigned DETW = P3W + 2;            // sum of three
	localparam int unsigned MAGW = DETW;               // magnitude
	localparam int unsigned NSTEP = MAGW + pit_pkg::FRAC_Q; // quotient bits
	localparam int unsigned RW   = MAGW + 1;
	localparam logic [pit_pkg::QUO_W-1:0] QCAP = pit_pkg::QUO_W'(1) << 33;

	typedef logic signed [CW-1:0]   crd_t;
	typedef logic signed [DW-1:0]   dif_t;
	typedef logic signed [DETW-1:0] det_t;

	typedef struct packed {
		logic                    q;      // query item
		logic                    rng;    // index out of range
		logic [pit_pkg::TOL_W-1:0] tol;
	} ctl_t;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// ---------------- configuration
	logic [pit_pkg::CCNT_W-1:0] cell_count_q;
	logic [pit_pkg::TOL_W-1:0]  tolerance_q;
	logic cfg_we;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q <= '0;
			tolerance_q  <= '0;
		end else if (cfg_we && paddr[1:0] == 2'b00) begin
			if (paddr[2] == pit_pkg::REG_CELL_COUNT)
				cell_count_q <= pwdata[pit_pkg::CCNT_W-1:0];
			else
				tolerance_q <= pwdata[pit_pkg::TOL_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == pit_pkg::REG_CELL_COUNT)
			prdata = {{(32-pit_pkg::CCNT_W){1'b0}}, cell_count_q};
		else
			prdata = {{(32-pit_pkg::TOL_W){1'b0}}, tolerance_q};
	end

	// ---------------- stage 0: accept, table writes, cell read
	logic acc;
	pit_pkg::op_t op_in;
	assign acc   = start & ~busy;
	assign op_in = pit_pkg::op_t'(op);

	logic vwe, cwe;
	assign vwe = acc && op_in == pit_pkg::OP_WR_VERTEX && 32'(index) < MAX_VERTICES;
	assign cwe = acc && op_in == pit_pkg::OP_WR_CELL && 32'(index) < MAX_CELLS;

	logic qry_in, rng_in;
	assign qry_in = acc && op_in == pit_pkg::OP_QUERY;
	assign rng_in = ({1'b0, index} >= cell_count_q) || (32'(index) >= MAX_CELLS);

	logic [47:0] cell_rd;
	pit_ram #(.WIDTH(48), .DEPTH(MAX_CELLS)) u_cell (
		.clk(clk), .we(cwe), .waddr(index[CA_W-1:0]),
		.wdata({corner3, corner2, corner1, corner0}),
		.re(qry_in), .raddr(index[CA_W-1:0]), .rdata(cell_rd)
	);

	logic vld_s1;
	ctl_t ctl_s1;
	crd_t px_s1, py_s1, pz_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= qry_in;
	end
	always_ff @(posedge clk) begin
		ctl_s1 <= '{q: 1'b1, rng: rng_in, tol: tolerance_q};
		px_s1 <= coord_x; py_s1 <= coord_y; pz_s1 <= coord_z;
	end

	// ---------------- stage 1: vertex reads, four ports by replicated RAMs
	logic [11:0] cn [4];
	logic [3:0]  cnok;
	crd_t vx_rd [4], vy_rd [4], vz_rd [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cn[k]   = cell_rd[12*k +: 12];
			cnok[k] = 32'(cn[k]) < MAX_VERTICES;
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_vtx
		logic [CW-1:0] xr, yr, zr;
		pit_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_x (
			.clk(clk), .we(vwe), .waddr(index[VA_W-1:0]), .wdata(coord_x),
			.re(vld_s1), .raddr(cn[k][VA_W-1:0]), .rdata(xr));
		pit_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_y (
			.clk(clk), .we(vwe), .waddr(index[VA_W-1:0]), .wdata(coord_y),
			.re(vld_s1), .raddr(cn[k][VA_W-1:0]), .rdata(yr));
		pit_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_z (
			.clk(clk), .we(vwe), .waddr(index[VA_W-1:0]), .wdata(coord_z),
			.re(vld_s1), .raddr(cn[k][VA_W-1:0]), .rdata(zr));
		assign vx_rd[k] = xr;
		assign vy_rd[k] = yr;
		assign vz_rd[k] = zr;
	end

	logic vld_s2;
	ctl_t ctl_s2;
	crd_t px_s2, py_s2, pz_s2;
	logic [3:0] cnok_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_s1;
		px_s2 <= px_s1; py_s2 <= py_s1; pz_s2 <= pz_s1;
		cnok_s2 <= cnok;
	end

	// ---------------- stage 2: differences for five determinants
	// det m uses corners c0..c3 with corner m-1 replaced by p (m=0: volume)
	crd_t vx [4], vy [4], vz [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			vx[k] = cnok_s2[k] ? vx_rd[k] : '0;
			vy[k] = cnok_s2[k] ? vy_rd[k] : '0;
			vz[k] = cnok_s2[k] ? vz_rd[k] : '0;
		end
	end

	dif_t d_s3 [5][3][3]; // [det][row u,v,w][axis]
	logic vld_s3;
	ctl_t ctl_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		ctl_s3 <= ctl_s2;
		for (int m = 0; m < 5; m++) begin
			crd_t ax [4], ay [4], az [4];
			for (int k = 0; k < 4; k++) begin
				ax[k] = (m == k + 1) ? px_s2 : vx[k];
				ay[k] = (m == k + 1) ? py_s2 : vy[k];
				az[k] = (m == k + 1) ? pz_s2 : vz[k];
			end
			for (int r = 0; r < 3; r++) begin
				d_s3[m][r][0] <= DW'(ax[r+1]) - DW'(ax[0]);
				d_s3[m][r][1] <= DW'(ay[r+1]) - DW'(ay[0]);
				d_s3[m][r][2] <= DW'(az[r+1]) - DW'(az[0]);
			end
		end
	end

	// ---------------- stage 3: two-by-two products
	logic signed [P2W-1:0] pp_s4 [5][6];
	dif_t u_s4 [5][3];
	logic vld_s4;
	ctl_t ctl_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		ctl_s4 <= ctl_s3;
		for (int m = 0; m < 5; m++) begin
			pp_s4[m][0] <= d_s3[m][1][1] * d_s3[m][2][2];
			pp_s4[m][1] <= d_s3[m][1][2] * d_s3[m][2][1];
			pp_s4[m][2] <= d_s3[m][1][2] * d_s3[m][2][0];
			pp_s4[m][3] <= d_s3[m][1][0] * d_s3[m][2][2];
			pp_s4[m][4] <= d_s3[m][1][0] * d_s3[m][2][1];
			pp_s4[m][5] <= d_s3[m][1][1] * d_s3[m][2][0];
			for (int a = 0; a < 3; a++) u_s4[m][a] <= d_s3[m][0][a];
		end
	end

	// ---------------- stage 4: minors
	logic signed [M2W-1:0] mn_s5 [5][3];
	dif_t u_s5 [5][3];
	logic vld_s5;
	ctl_t ctl_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else         vld_s5 <= vld_s4;
	end
	always_ff @(posedge clk) begin
		ctl_s5 <= ctl_s4;
		for (int m = 0; m < 5; m++) begin
			for (int a = 0; a < 3; a++)
				mn_s5[m][a] <= M2W'(pp_s4[m][2*a]) - M2W'(pp_s4[m][2*a+1]);
			u_s5[m] <= u_s4[m];
		end
	end

	// ---------------- stage 5: row times each half of the minor
	logic signed [PLW-1:0] tl_s6 [5][3];
	logic signed [PHW-1:0] th_s6 [5][3];
	logic vld_s6;
	ctl_t ctl_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else         vld_s6 <= vld_s5;
	end
	always_ff @(posedge clk) begin
		ctl_s6 <= ctl_s5;
		for (int m = 0; m < 5; m++)
			for (int a = 0; a < 3; a++) begin
				tl_s6[m][a] <= u_s5[m][a] * $signed({1'b0, mn_s5[m][a][ML_W-1:0]});
				th_s6[m][a] <= u_s5[m][a] * $signed(mn_s5[m][a][M2W-1:ML_W]);
			end
	end

	// ---------------- stage 6: sums of the low and high parts
	logic signed [SLW-1:0] sl_s7 [5];
	logic signed [SHW-1:0] sh_s7 [5];
	logic vld_s7;
	ctl_t ctl_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else         vld_s7 <= vld_s6;
	end
	always_ff @(posedge clk) begin
		ctl_s7 <= ctl_s6;
		for (int m = 0; m < 5; m++) begin
			sl_s7[m] <= SLW'(tl_s6[m][0]) + SLW'(tl_s6[m][1]) + SLW'(tl_s6[m][2]);
			sh_s7[m] <= SHW'(th_s6[m][0]) + SHW'(th_s6[m][1]) + SHW'(th_s6[m][2]);
		end
	end

	// ---------------- stage 7: determinants
	det_t det_s8 [5];
	logic vld_s8;
	ctl_t ctl_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else         vld_s8 <= vld_s7;
	end
	always_ff @(posedge clk) begin
		ctl_s8 <= ctl_s7;
		for (int m = 0; m < 5; m++)
			det_s8[m] <= (DETW'(sh_s7[m]) <<< ML_W) + DETW'(sl_s7[m]);
	end

	// ---------------- stage 8: magnitudes and signs
	logic [MAGW-1:0] vm_s9;
	logic [MAGW-1:0] nm_s9 [4];
	logic [3:0] neg_s9;
	logic zero_s9;
	logic vld_s9;
	ctl_t ctl_s9;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s9 <= 1'b0;
		else         vld_s9 <= vld_s8;
	end
	always_ff @(posedge clk) begin
		ctl_s9  <= ctl_s8;
		zero_s9 <= det_s8[0] == '0;
		vm_s9   <= det_s8[0][DETW-1] ? MAGW'(-det_s8[0]) : MAGW'(det_s8[0]);
		for (int j = 0; j < 4; j++) begin
			nm_s9[j]  <= det_s8[j+1][DETW-1] ? MAGW'(-det_s8[j+1]) : MAGW'(det_s8[j+1]);
			neg_s9[j] <= det_s8[j+1][DETW-1] ^ det_s8[0][DETW-1];
		end
	end

	// ---------------- divider pipeline: one quotient bit per stage
	typedef struct packed {
		logic [RW-1:0]            rem;
		logic [MAGW-1:0]          num;
		logic [pit_pkg::QUO_W-1:0] quo;
	} lane_t;

	lane_t           ln_q  [NSTEP+1][4];
	logic [MAGW-1:0] dv_q  [NSTEP+1];
	logic [3:0]      ng_q  [NSTEP+1];
	logic            zr_q  [NSTEP+1];
	ctl_t            ct_q  [NSTEP+1];
	logic            vd_q  [NSTEP+1];

	always_comb begin
		dv_q[0] = vm_s9;
		ng_q[0] = neg_s9;
		zr_q[0] = zero_s9;
		ct_q[0] = ctl_s9;
		vd_q[0] = vld_s9;
		for (int j = 0; j < 4; j++)
			ln_q[0][j] = '{rem: '0, num: nm_s9[j], quo: '0};
	end

	for (genvar s = 0; s < NSTEP; s++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vd_q[s+1] <= 1'b0;
			else         vd_q[s+1] <= vd_q[s];
		end
		always_ff @(posedge clk) begin
			dv_q[s+1] <= dv_q[s];
			ng_q[s+1] <= ng_q[s];
			zr_q[s+1] <= zr_q[s];
			ct_q[s+1] <= ct_q[s];
			for (int j = 0; j < 4; j++) begin
				logic [RW-1:0] sh;
				logic [RW:0]   df;
				logic [pit_pkg::QUO_W:0] qn;
				sh = {ln_q[s][j].rem[RW-2:0], ln_q[s][j].num[MAGW-1]};
				df = {1'b0, sh} - {2'b00, dv_q[s]};
				// keep the bit shifted out so a capped quotient stays capped
				qn = {ln_q[s][j].quo, ~df[RW]};
				ln_q[s+1][j].rem <= df[RW] ? sh : df[RW-1:0];
				ln_q[s+1][j].num <= {ln_q[s][j].num[MAGW-2:0], 1'b0};
				ln_q[s+1][j].quo <= (qn > {1'b0, QCAP}) ? QCAP : qn[pit_pkg::QUO_W-1:0];
			end
		end
	end

	// ---------------- final stage: sign, saturate, tolerance
	localparam logic [pit_pkg::QUO_W-1:0] QMAXP = pit_pkg::QUO_W'(32'h7FFF_FFFF);
	localparam logic [pit_pkg::QUO_W-1:0] QMAXN = pit_pkg::QUO_W'(1) << 31;

	logic signed [31:0] wt [4];
	logic ins;
	always_comb begin
		ins = 1'b1;
		for (int j = 0; j < 4; j++) begin
			logic [pit_pkg::QUO_W-1:0] qq;
			qq = ln_q[NSTEP][j].quo;
			if (ng_q[NSTEP][j] && qq != '0)
				wt[j] = (qq > QMAXN) ? 32'sh8000_0000 : -$signed(qq[31:0]);
			else
				wt[j] = (qq > QMAXP) ? 32'sh7FFF_FFFF : $signed(qq[31:0]);
			if (34'(signed'(wt[j])) < -$signed({4'b0, ct_q[NSTEP].tol}))
				ins = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= vd_q[NSTEP];
	end
	always_ff @(posedge clk) begin
		if (ct_q[NSTEP].rng || zr_q[NSTEP]) begin
			status     <= ct_q[NSTEP].rng ? pit_pkg::ST_RANGE : pit_pkg::ST_DEGEN;
			inside_res <= 1'b0;
			weight0 <= '0; weight1 <= '0; weight2 <= '0; weight3 <= '0;
		end else begin
			status     <= pit_pkg::ST_OK;
			inside_res <= ins;
			weight0 <= wt[0]; weight1 <= wt[1]; weight2 <= wt[2]; weight3 <= wt[3];
		end
	end
endmodule

// File: rtl/core/pit_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module pit_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

// File: bench/point_in_tetrahedron_test_core_test.sv
// Self-checking bench for the point-in-tetrahedron core: table loads, queries, weight checks.
module point_in_tetrahedron_test_core_test;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		pit_pkg::op_t       op;
		logic [11:0]        index;
		logic signed [23:0] x, y, z;
		logic [11:0]        c0, c1, c2, c3;
	} item_t;

	typedef struct {
		logic               in_cell;
		pit_pkg::status_t   status;
		logic signed [31:0] w [4];
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] op = 2'd0;
	logic [11:0] index = 12'd0;
	logic signed [23:0] coord_x = 24'sd0, coord_y = 24'sd0, coord_z = 24'sd0;
	logic [11:0] corner0 = 12'd0, corner1 = 12'd0, corner2 = 12'd0, corner3 = 12'd0;
	logic done, inside_res, pready;
	logic [1:0] status;
	logic signed [31:0] weight0, weight1, weight2, weight3;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;

	point_in_tetrahedron_test_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .index(index), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.corner0(corner0), .corner1(corner1), .corner2(corner2), .corner3(corner3),
		.done(done), .inside_res(inside_res), .status(status),
		.weight0(weight0), .weight1(weight1), .weight2(weight2), .weight3(weight3),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	item_t   pending [$];
	answer_t answers [$];
	int      errors = 0;
	bit      quiet = 1'b0;

	// predictor copy of the tables and registers
	logic signed [23:0] tab_x [4096], tab_y [4096], tab_z [4096];
	logic [11:0]        tab_c [4096][4];
	logic [12:0]        cur_cell_count = 13'd0;
	logic [29:0]        cur_tolerance = 30'd0;

	// generator view of what has been loaded
	bit                 vert_loaded [4096];
	bit                 cell_loaded [4096];
	int                 vert_list [$], cell_list [$];
	logic signed [23:0] gen_x [4096], gen_y [4096], gen_z [4096];
	logic [11:0]        gen_c [4096][4];
	int                 gen_cell_count = 0;

	initial begin
		for (int i = 0; i < 4096; i++) begin
			tab_x[i] = '0; tab_y[i] = '0; tab_z[i] = '0;
			for (int k = 0; k < 4; k++) tab_c[i][k] = '0;
		end
	end

	function automatic wide_t volume(longint a [3], longint b [3], longint c [3], longint d [3]);
		wide_t u [3], v [3], w [3];
		for (int k = 0; k < 3; k++) begin
			u[k] = b[k] - a[k];
			v[k] = c[k] - a[k];
			w[k] = d[k] - a[k];
		end
		return u[0]*v[1]*w[2] - u[0]*v[2]*w[1] - u[1]*v[0]*w[2]
			+ u[1]*v[2]*w[0] + u[2]*v[0]*w[1] - u[2]*v[1]*w[0];
	endfunction

	function automatic answer_t locate_point(item_t it);
		answer_t a;
		longint  pts [4][3], pt [3], c [4][3];
		wide_t   vol, dj;
		logic [127:0] vm, dm, q;
		longint  wv;
		a.in_cell = 1'b0;
		a.status = pit_pkg::ST_OK;
		for (int j = 0; j < 4; j++) a.w[j] = '0;
		if (it.index >= cur_cell_count) begin
			a.status = pit_pkg::ST_RANGE;
			return a;
		end
		for (int k = 0; k < 4; k++) begin
			pts[k][0] = tab_x[tab_c[it.index][k]];
			pts[k][1] = tab_y[tab_c[it.index][k]];
			pts[k][2] = tab_z[tab_c[it.index][k]];
		end
		pt[0] = it.x; pt[1] = it.y; pt[2] = it.z;
		vol = volume(pts[0], pts[1], pts[2], pts[3]);
		if (vol == 0) begin
			a.status = pit_pkg::ST_DEGEN;
			return a;
		end
		vm = vol < 0 ? -vol : vol;
		a.in_cell = 1'b1;
		for (int j = 0; j < 4; j++) begin
			for (int k = 0; k < 4; k++) c[k] = (k == j) ? pt : pts[k];
			dj = volume(c[0], c[1], c[2], c[3]);
			dm = dj < 0 ? -dj : dj;
			q = (dm << pit_pkg::FRAC_Q) / vm;
			if (q > (128'd1 << 33)) q = 128'd1 << 33;
			wv = longint'(q[63:0]);
			if ((dj < 0) != (vol < 0)) wv = -wv;
			if (wv > 64'sd2147483647) wv = 64'sd2147483647;
			if (wv < -64'sd2147483648) wv = -64'sd2147483648;
			if (wv < -longint'(cur_tolerance)) a.in_cell = 1'b0;
			a.w[j] = wv[31:0];
		end
		return a;
	endfunction

	function automatic void take_item(item_t it);
		case (it.op)
			pit_pkg::OP_WR_VERTEX: begin
				tab_x[it.index] = it.x; tab_y[it.index] = it.y; tab_z[it.index] = it.z;
			end
			pit_pkg::OP_WR_CELL: begin
				tab_c[it.index][0] = it.c0; tab_c[it.index][1] = it.c1;
				tab_c[it.index][2] = it.c2; tab_c[it.index][3] = it.c3;
			end
			pit_pkg::OP_QUERY: answers.push_back(locate_point(it));
			default: ;
		endcase
	endfunction

	// driver: present queued items, idle now and then
	always @(posedge clk) begin
		item_t nx;
		if (start && !busy) take_item('{pit_pkg::op_t'(op), index, coord_x, coord_y, coord_z,
			corner0, corner1, corner2, corner3});
		if (pending.size() > 0 && (quiet || $urandom_range(99) >= 13)) begin
			nx = pending.pop_front();
			op <= nx.op; index <= nx.index;
			coord_x <= nx.x; coord_y <= nx.y; coord_z <= nx.z;
			corner0 <= nx.c0; corner1 <= nx.c1; corner2 <= nx.c2; corner3 <= nx.c3;
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// monitor
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && done) begin
			if (answers.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				a = answers.pop_front();
				if (inside_res !== a.in_cell) report("inside_res", inside_res, a.in_cell);
				if (status !== a.status) report("status", status, a.status);
				if (weight0 !== a.w[0]) report("weight0", weight0, a.w[0]);
				if (weight1 !== a.w[1]) report("weight1", weight1, a.w[1]);
				if (weight2 !== a.w[2]) report("weight2", weight2, a.w[2]);
				if (weight3 !== a.w[3]) report("weight3", weight3, a.w[3]);
			end
		end
	end

	task automatic reg_write(logic [0:0] which, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {which, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (which == pit_pkg::REG_CELL_COUNT) begin
			cur_cell_count = value[12:0];
			gen_cell_count = value[12:0];
		end else begin
			cur_tolerance = value[29:0];
		end
	endtask

	task automatic drain();
		do @(negedge clk); while (pending.size() > 0 || start || answers.size() > 0);
		// writes leave no result, so wait out the pipeline
		repeat (200) @(negedge clk);
	endtask

	function automatic logic signed [23:0] rnd_coord(int k);
		return 24'($signed($urandom) >>> (31 - k));
	endfunction

	function automatic void put_vertex(int i, logic signed [23:0] x, y, z);
		pending.push_back('{pit_pkg::OP_WR_VERTEX, 12'(i), x, y, z,
			12'd0, 12'd0, 12'd0, 12'd0});
		if (!vert_loaded[i]) vert_list.push_back(i);
		vert_loaded[i] = 1'b1;
		gen_x[i] = x; gen_y[i] = y; gen_z[i] = z;
	endfunction

	function automatic void put_cell(int i, int a, b, c, d);
		pending.push_back('{pit_pkg::OP_WR_CELL, 12'(i), rnd_coord(23), rnd_coord(23),
			rnd_coord(23), 12'(a), 12'(b), 12'(c), 12'(d)});
		if (!cell_loaded[i]) cell_list.push_back(i);
		cell_loaded[i] = 1'b1;
		gen_c[i][0] = a; gen_c[i][1] = b; gen_c[i][2] = c; gen_c[i][3] = d;
	endfunction

	function automatic void put_query(int i, logic signed [23:0] x, y, z);
		pending.push_back('{pit_pkg::OP_QUERY, 12'(i), x, y, z, 12'($urandom),
			12'($urandom), 12'($urandom), 12'($urandom)});
	endfunction

	function automatic void random_item();
		int r, i, k;
		longint sx, sy, sz;
		r = $urandom_range(99);
		if (r < 3) begin
			pending.push_back('{pit_pkg::OP_NONE, 12'($urandom), rnd_coord(23), rnd_coord(23),
				rnd_coord(23), 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom)});
		end else if (r < 25 || vert_list.size() < 4) begin
			k = $urandom_range(23, 6);
			i = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(63);
			put_vertex(i, rnd_coord(k), rnd_coord(k), rnd_coord(k));
		end else if (r < 40 || cell_list.size() == 0) begin
			i = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(31);
			put_cell(i, vert_list[$urandom_range(vert_list.size() - 1)],
				vert_list[$urandom_range(vert_list.size() - 1)],
				vert_list[$urandom_range(vert_list.size() - 1)],
				vert_list[$urandom_range(vert_list.size() - 1)]);
		end else begin
			i = -1;
			for (int t = 0; t < 8 && i < 0; t++) begin
				k = cell_list[$urandom_range(cell_list.size() - 1)];
				if (k < gen_cell_count) i = k;
			end
			if (i < 0 || $urandom_range(9) == 0) begin
				if (gen_cell_count <= 4095)
					put_query($urandom_range(4095, gen_cell_count), rnd_coord(23),
						rnd_coord(23), rnd_coord(23));
			end else if ($urandom_range(3) == 0) begin
				put_query(i, rnd_coord(23), rnd_coord(23), rnd_coord(23));
			end else begin
				// aim near the centroid so many points land inside
				sx = 0; sy = 0; sz = 0;
				for (int c = 0; c < 4; c++) begin
					sx += gen_x[gen_c[i][c]]; sy += gen_y[gen_c[i][c]];
					sz += gen_z[gen_c[i][c]];
				end
				k = $urandom_range(20, 2);
				put_query(i, 24'(sx / 4 + rnd_coord(k)), 24'(sy / 4 + rnd_coord(k)),
					24'(sz / 4 + rnd_coord(k)));
			end
		end
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		reg_write(pit_pkg::REG_CELL_COUNT, 32'd4096);
		reg_write(pit_pkg::REG_TOLERANCE, 32'd0);
		put_vertex(0, 24'sd0, 24'sd0, 24'sd0);
		put_vertex(1, 24'sd4096, 24'sd0, 24'sd0);
		put_vertex(2, 24'sd0, 24'sd4096, 24'sd0);
		put_vertex(3, 24'sd0, 24'sd0, 24'sd4096);
		put_vertex(4, -24'sd8388608, -24'sd8388608, -24'sd8388608);
		put_vertex(4095, 24'sd8388607, 24'sd8388607, 24'sd8388607);
		put_vertex(5, 24'sd8388607, -24'sd8388608, 24'sd8388607);
		put_cell(0, 0, 1, 2, 3);
		put_cell(1, 0, 1, 2, 2);
		put_cell(2, 3, 2, 1, 0);
		put_cell(4095, 4, 4095, 5, 1);
		put_query(0, 24'sd1024, 24'sd1024, 24'sd1024);
		put_query(0, -24'sd1, 24'sd0, 24'sd0);
		put_query(0, 24'sd4096, 24'sd0, 24'sd0);
		put_query(0, 24'sd8388607, 24'sd8388607, 24'sd8388607);
		put_query(0, -24'sd8388608, -24'sd8388608, -24'sd8388608);
		put_query(1, 24'sd100, 24'sd100, 24'sd100);
		put_query(2, 24'sd1024, 24'sd1024, -24'sd1);
		put_query(4095, 24'sd0, 24'sd0, 24'sd0);
		put_query(4095, 24'sd8388607, -24'sd8388608, 24'sd0);
		pending.push_back('{pit_pkg::OP_NONE, 12'hFFF, -24'sd1, -24'sd1, -24'sd1,
			12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
		put_query(0, 24'sd2048, 24'sd1, 24'sd1);
		drain();

		reg_write(pit_pkg::REG_TOLERANCE, $urandom_range(1 << 20));
		repeat (250) random_item();
		drain();

		reg_write(pit_pkg::REG_CELL_COUNT, 32'd0);
		reg_write(pit_pkg::REG_TOLERANCE, 32'd1073741823);
		repeat (60) random_item();
		drain();

		reg_write(pit_pkg::REG_CELL_COUNT, $urandom_range(4096, 1));
		reg_write(pit_pkg::REG_TOLERANCE, $urandom_range(1073741823));
		quiet = 1'b1;
		repeat (200) random_item();
		drain();
		quiet = 1'b0;

		reg_write(pit_pkg::REG_CELL_COUNT, 32'd4096);
		reg_write(pit_pkg::REG_TOLERANCE, 32'd0);
		repeat (240) random_item();
		drain();

		if (errors == 0)
			$display("** point_in_tetrahedron_test_core: PASSED **");
		else
			$display("** point_in_tetrahedron_test_core: FAILED **");
		$finish;
	end

	initial begin
		#2000000;
		$display("** point_in_tetrahedron_test_core: FAILED **");
		$finish;
	end
endmodule
